FILE: hw/rtl/bsfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfs_pkg
// Shared constants and types for the byte stream field splitter.
// ----------------------------------------------------------------------------
package bsfs_pkg;

  // default for the longest separator the window can hold
  localparam int MAX_SEP_DEF = 8;

  // separator register carries at most this many bytes
  localparam int SEP_BYTES = 8;

  localparam int BYTE_W     = 8;
  localparam int SEP_LEN_W  = 4;
  localparam int SEP_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEP_LEN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEP_BYTES = 2'd1;

  // reset values of the registers
  localparam logic [SEP_LEN_W-1:0]  SEP_LEN_RST   = 4'd1;
  localparam logic [SEP_DATA_W-1:0] SEP_BYTES_RST = 64'd44;

  // head part of one request's result batch
  typedef struct packed {
    logic              head_vld;   // a head result (a byte or a field end) is present
    logic              head_fe;    // that result is a field end, else a byte
    logic [BYTE_W-1:0] head_byte;
    logic              fin_end;    // source ends with this request
  } batch_ctl_t;

endpackage

FILE: hw/rtl/bsfs_split_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfs_split_core
// Holds the configuration and the match window, and turns one input request
// into a result batch combinationally.
// ----------------------------------------------------------------------------
module bsfs_split_core
  import bsfs_pkg::*;
#(
  parameter  int MAX_SEP = MAX_SEP_DEF,
  localparam int LMAX    = (MAX_SEP < SEP_BYTES) ? MAX_SEP : SEP_BYTES,
  localparam int CNT_W   = $clog2(LMAX + 1),
  localparam int IDX_W   = (LMAX > 1) ? $clog2(LMAX) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         step_en,
  input  logic [BYTE_W-1:0]            in_byte,
  input  logic                         in_present,
  input  logic                         in_end,
  output batch_ctl_t                   bat_ctl,
  output logic [LMAX-1:0][BYTE_W-1:0]  bat_fl,
  output logic [CNT_W-1:0]             bat_cnt
);

  logic [SEP_LEN_W-1:0]          sep_len_r;
  logic [SEP_DATA_W-1:0]         sep_bytes_r;
  logic [LMAX-1:0][BYTE_W-1:0]   win_r, win_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic [CNT_W-1:0]              eff_len;
  logic [LMAX-1:0][BYTE_W-1:0]   win_ext, win_sh;
  logic [CNT_W-1:0]              cnt_inc;
  logic                          match;

  // effective separator length, capped at the window depth
  assign eff_len = (sep_len_r > SEP_LEN_W'(LMAX)) ? CNT_W'(LMAX) : CNT_W'(sep_len_r);

  // window with the new byte appended, its compare and its one-step shift
  always_comb begin
    win_ext = win_r;
    win_ext[cnt_r[IDX_W-1:0]] = in_byte;
    cnt_inc = cnt_r + CNT_W'(1);
    match = 1'b1;
    for (int k = 0; k < LMAX; k++) begin
      if ((CNT_W'(k) < eff_len) && (win_ext[k] != sep_bytes_r[8*k +: 8])) begin
        match = 1'b0;
      end
    end
    win_sh = win_ext;
    for (int k = 0; k < LMAX - 1; k++) begin
      win_sh[k] = win_ext[k + 1];
    end
  end

  // split decision and batch build
  always_comb begin
    bat_ctl.head_vld  = 1'b0;
    bat_ctl.head_fe   = 1'b0;
    bat_ctl.head_byte = '0;
    bat_ctl.fin_end   = in_end;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (in_present) begin
      if (eff_len == '0) begin
        bat_ctl.head_vld  = 1'b1;
        bat_ctl.head_byte = in_byte;
      end else if (cnt_inc == eff_len) begin
        bat_ctl.head_vld = 1'b1;
        if (match) begin
          bat_ctl.head_fe = 1'b1;
          cnt_nxt = '0;
        end else begin
          bat_ctl.head_byte = win_ext[0];
          win_nxt = win_sh;
          cnt_nxt = eff_len - CNT_W'(1);
        end
      end else begin
        win_nxt = win_ext;
        cnt_nxt = cnt_inc;
      end
    end
    // at the end of the source every held byte is flushed
    bat_fl  = win_nxt;
    bat_cnt = in_end ? cnt_nxt : '0;
    if (in_end) begin
      cnt_nxt = '0;
    end
  end

  // configuration and window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r   <= SEP_LEN_RST;
      sep_bytes_r <= SEP_BYTES_RST;
      cnt_r       <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_SEP_LEN) begin
        sep_len_r <= cfg_wdata[SEP_LEN_W-1:0];
        cnt_r     <= '0;
      end else if (cfg_addr == REG_SEP_BYTES) begin
        sep_bytes_r <= cfg_wdata[SEP_DATA_W-1:0];
      end
    end else if (step_en) begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes carry no reset
  always_ff @(posedge clk) begin
    if (step_en) begin
      win_r <= win_nxt;
    end
  end

  // the window never holds a full separator between requests
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) || (cnt_r < eff_len))
    else $error("window count reached separator length");

endmodule

FILE: hw/rtl/bsfs_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfs_emitter
// Result register: holds one request's batch and sends its results out one
// per cycle while out_tready is high, merging the final field end onto a trailing byte.
// ----------------------------------------------------------------------------
module bsfs_emitter
  import bsfs_pkg::*;
#(
  parameter  int MAX_SEP = MAX_SEP_DEF,
  localparam int LMAX    = (MAX_SEP < SEP_BYTES) ? MAX_SEP : SEP_BYTES,
  localparam int CNT_W   = $clog2(LMAX + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  batch_ctl_t                   bat_ctl,
  input  logic [LMAX-1:0][BYTE_W-1:0]  bat_fl,
  input  logic [CNT_W-1:0]             bat_cnt,
  output logic                         can_load,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // out_byte
  output logic [2:0]                   out_tuser,  // out_byte_valid, field_end, source_done
  output logic                         out_tlast   // run_last
);

  logic                        hd_pend_r, hd_pend_nxt;
  logic                        hd_fe_r, hd_fe_nxt;
  logic [BYTE_W-1:0]           hd_byte_r, hd_byte_nxt;
  logic [LMAX-1:0][BYTE_W-1:0] fl_r, fl_nxt;
  logic [CNT_W-1:0]            fl_cnt_r, fl_cnt_nxt;
  logic                        end_r, end_nxt;
  logic                        mk_pend_r, mk_pend_nxt;

  logic busy, take, res_vld, res_fe, res_sd;
  logic [BYTE_W-1:0] res_byte;

  assign busy = hd_pend_r | (fl_cnt_r != '0) | mk_pend_r;
  assign take = busy & out_tready;

  // current result: head first, then flushed bytes, then a lone field end
  always_comb begin
    res_byte  = '0;
    res_vld   = 1'b0;
    res_fe    = 1'b0;
    res_sd    = 1'b0;
    out_tlast = 1'b0;
    if (hd_pend_r) begin
      res_vld   = ~hd_fe_r;
      res_byte  = hd_fe_r ? '0 : hd_byte_r;
      out_tlast = (fl_cnt_r == '0) & ~mk_pend_r;
      res_fe    = hd_fe_r | (out_tlast & end_r);
      res_sd    = ~hd_fe_r & out_tlast & end_r;
    end else if (fl_cnt_r != '0) begin
      res_vld   = 1'b1;
      res_byte  = fl_r[0];
      out_tlast = (fl_cnt_r == CNT_W'(1)) & ~mk_pend_r;
      res_fe    = out_tlast & end_r;
      res_sd    = out_tlast & end_r;
    end else if (mk_pend_r) begin
      res_fe    = 1'b1;
      res_sd    = 1'b1;
      out_tlast = 1'b1;
    end
  end

  assign out_tvalid = busy;
  assign out_tdata  = res_byte;
  assign out_tuser  = {res_sd, res_fe, res_vld};
  assign can_load   = ~busy | (take & out_tlast);

  // next state: advance on a taken result, reload on a new batch
  always_comb begin
    hd_pend_nxt = hd_pend_r;
    hd_fe_nxt   = hd_fe_r;
    hd_byte_nxt = hd_byte_r;
    fl_nxt      = fl_r;
    fl_cnt_nxt  = fl_cnt_r;
    end_nxt     = end_r;
    mk_pend_nxt = mk_pend_r;
    if (take) begin
      if (hd_pend_r) begin
        hd_pend_nxt = 1'b0;
      end else if (fl_cnt_r != '0) begin
        for (int k = 0; k < LMAX - 1; k++) begin
          fl_nxt[k] = fl_r[k + 1];
        end
        fl_cnt_nxt = fl_cnt_r - CNT_W'(1);
      end else begin
        mk_pend_nxt = 1'b0;
      end
    end
    if (load) begin
      hd_pend_nxt = bat_ctl.head_vld;
      hd_fe_nxt   = bat_ctl.head_fe;
      hd_byte_nxt = bat_ctl.head_byte;
      fl_nxt      = bat_fl;
      fl_cnt_nxt  = bat_cnt;
      end_nxt     = bat_ctl.fin_end;
      // final field end needs its own result unless a byte closes the batch
      mk_pend_nxt = bat_ctl.fin_end &
                    ~((bat_cnt != '0) | (bat_ctl.head_vld & ~bat_ctl.head_fe));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_pend_r <= 1'b0;
      fl_cnt_r  <= '0;
      mk_pend_r <= 1'b0;
      end_r     <= 1'b0;
    end else begin
      hd_pend_r <= hd_pend_nxt;
      fl_cnt_r  <= fl_cnt_nxt;
      mk_pend_r <= mk_pend_nxt;
      end_r     <= end_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hd_fe_r   <= hd_fe_nxt;
    hd_byte_r <= hd_byte_nxt;
    fl_r      <= fl_nxt;
  end

  // source done always rides on a field end
  a_sd_has_fe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("source done without field end");

  // source done only on the last result of a request
  a_sd_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("source done before end of batch");

  // a byte carries a field end only as the final one of a source
  a_byte_fe_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tuser[1] |-> out_tuser[2])
    else $error("separator end marked on a data byte");

endmodule

FILE: hw/rtl/byte_stream_field_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_field_splitter_top
// Splits a byte stream into fields at a configurable separator.
// ----------------------------------------------------------------------------
// A request's batch goes into a single result register whose results leave
// one per cycle while out_tready is high, so a request with at most one
// result runs at one request per clock then, and one with more (up to eight,
// when a source end flushes the window) holds the input until its last one is
// taken. Window byte compares are parallel and combinational; no clearing pass after
// reset. Write the registers only while no results are outstanding.
// ----------------------------------------------------------------------------
module byte_stream_field_splitter_top
  import bsfs_pkg::*;
#(
  parameter int MAX_SEP = MAX_SEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // in_byte
  input  logic                  in_tuser,   // byte_present
  input  logic                  in_tlast,   // source_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // out_byte
  output logic [2:0]            out_tuser,  // out_byte_valid, field_end, source_done
  output logic                  out_tlast   // run_last
);

  localparam int LMAX  = (MAX_SEP < SEP_BYTES) ? MAX_SEP : SEP_BYTES;
  localparam int CNT_W = $clog2(LMAX + 1);

  batch_ctl_t                  bat_ctl;
  logic [LMAX-1:0][BYTE_W-1:0] bat_fl;
  logic [CNT_W-1:0]            bat_cnt;
  logic                        can_load, step_en;

  // a request is accepted whenever the result register can take its batch
  assign in_tready = can_load;
  assign step_en   = in_tvalid & can_load;

  bsfs_split_core #(
    .MAX_SEP (MAX_SEP)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .step_en    (step_en),
    .in_byte    (in_tdata),
    .in_present (in_tuser),
    .in_end     (in_tlast),
    .bat_ctl    (bat_ctl),
    .bat_fl     (bat_fl),
    .bat_cnt    (bat_cnt)
  );

  bsfs_emitter #(
    .MAX_SEP (MAX_SEP)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .bat_ctl    (bat_ctl),
    .bat_fl     (bat_fl),
    .bat_cnt    (bat_cnt),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
